/* hw/rtl/double_extended_float_converter_core_macros.svh */
// Assertion macros shared by the checker
`ifndef DOUBLE_EXTENDED_FLOAT_CONVERTER_CORE_MACROS_SVH
`define DOUBLE_EXTENDED_FLOAT_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define DXF_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("dxf check failed");

// next-cycle implication
`define DXF_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("dxf check failed");

`endif

/* hw/rtl/dxf_pkg.sv */
package dxf_pkg;

    localparam int unsigned WordW = 80;

    localparam logic [14:0] ExtExpMax  = 15'd32767;
    localparam logic [10:0] DblExpMax  = 11'h7FF;
    localparam logic [63:0] TopBit     = 64'h8000_0000_0000_0000;
    localparam logic [14:0] ExtSubBase = 15'd15372;  // 16383 - 1074 + 63
    localparam logic [14:0] ExtNrmOfs  = 15'd15360;  // 16383 - 1023

    localparam logic REQ_TO_EXT = 1'b0;
    localparam logic REQ_TO_DBL = 1'b1;

    // per-byte nonzero flags and leading-zero counts
    typedef struct packed {
        logic [7:0]      nz;
        logic [7:0][2:0] lz8;
    } grp_lz_t;

endpackage

/* hw/rtl/double_extended_float_converter_core.sv */
// Double <-> 80-bit extended float converter.
// Input channel s_axis: tuser = req_type (0 double->extended, 1 extended->double),
// tdata = operand_bits [63:0], operand_sign_exp [79:64].
// Output channel m_axis: tdata = result_bits [63:0], result_sign_exp [79:64].
// One result word per input word, in order.
// Each word passes the capture, byte-count, merge, normalize and output registers.
// Throughput: one word per cycle while the receiver does not stall; the byte-wise
// leading-zero count, its merge, the normalizing shift and the rounding each take one register stage.
// Reset clears all stage valid bits; the block accepts words right after reset.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops;
// no word is lost or repeated. s_axis_tready is high whenever the output
// register is empty or being taken.
module double_extended_float_converter_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [dxf_pkg::WordW-1:0]   s_axis_tdata,  // operand_bits, operand_sign_exp
    input  logic                        s_axis_tuser,  // req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [dxf_pkg::WordW-1:0]   m_axis_tdata   // result_bits, result_sign_exp
);
    import dxf_pkg::*;

    logic en;
    logic [4:0] vld_reg, vld_next;

    // stage 1: captured input
    logic        s1_type_reg;
    logic [63:0] s1_bits_reg;
    logic [15:0] s1_se_reg;

    // stage 2: byte counts
    logic        s2_type_reg;
    logic [63:0] s2_bits_reg, s2_val_reg;
    logic [15:0] s2_se_reg;
    grp_lz_t     s2_grp_reg, s2_grp_next;
    logic [63:0] s2_val_next;

    // stage 3: full count
    logic        s3_type_reg;
    logic [63:0] s3_bits_reg, s3_val_reg;
    logic [15:0] s3_se_reg;
    logic [5:0]  s3_lz_reg, s3_lz_next;
    logic        s3_zero_reg, s3_zero_next;

    // stage 4: normalized
    logic        s4_type_reg;
    logic [63:0] s4_bits_reg, s4_mn_reg, s4_mn_next;
    logic [14:0] s4_exp0_reg, s4_exp0_next;
    logic        s4_sign_reg;
    logic        s4_inf_reg, s4_inf_next;
    logic        s4_zero_reg;
    logic        s4_nrm_reg, s4_nrm_next;
    logic        s4_flush_reg, s4_flush_next;
    logic [6:0]  s4_sh_reg, s4_sh_next;
    logic [10:0] s4_eb_reg, s4_eb_next;
    logic signed [17:0] ue;
    logic signed [17:0] dsub;

    // output
    logic [63:0] out_bits_reg, out_bits_next;
    logic [15:0] out_se_reg, out_se_next;
    logic [63:0] sig;
    logic [63:0] dbits;
    logic [10:0] e0;
    logic [51:0] f0;

    assign en            = !vld_reg[4] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[4];
    assign m_axis_tdata  = {out_se_reg, out_bits_reg};

    // valid bits advance with the data
    always_comb
    begin
        vld_next = {vld_reg[3:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 2 logic: operand to count, per-byte counts
    assign s2_val_next = (s1_type_reg == REQ_TO_DBL) ? s1_bits_reg
                                                      : {12'd0, s1_bits_reg[51:0]};

    dxf_lzc_group u_lzc
    (
        .val (s2_val_next),
        .grp (s2_grp_next)
    );

    // stage 3 logic: merge byte counts
    always_comb
    begin
        s3_lz_next   = '0;
        s3_zero_next = 1'b1;
        for (int g = 0; g < 8; g++)
        begin
            if (s2_grp_reg.nz[g])
            begin
                s3_lz_next   = {3'(7 - g), s2_grp_reg.lz8[g]};
                s3_zero_next = 1'b0;
            end
        end
    end

    // stage 4 logic: normalize and find exponent and shift
    always_comb
    begin
        s4_mn_next    = s3_val_reg << s3_lz_reg;
        s4_exp0_next  = ExtSubBase - {9'd0, s3_lz_reg};
        ue            = $signed({3'd0, s3_se_reg[14:0]}) - $signed({12'd0, s3_lz_reg})
                        - 18'sd16383;
        s4_inf_next   = (s3_se_reg[14:0] == ExtExpMax) ||
                        (!s3_zero_reg && (ue > 18'sd1023));
        s4_nrm_next   = (ue >= -18'sd1022);
        dsub          = -18'sd1022 - ue;
        s4_flush_next = !s4_nrm_next && (dsub > 18'sd53);
        s4_sh_next    = s4_nrm_next ? 7'd11 : 7'(dsub[5:0] + 7'd11);
        s4_eb_next    = 11'(ue + 18'sd1022);
    end

    // stage 5 logic: round and pack
    dxf_round u_round
    (
        .mn    (s4_mn_reg),
        .shamt (s4_sh_reg),
        .flush (s4_flush_reg),
        .sig   (sig)
    );

    always_comb
    begin
        e0    = s4_bits_reg[62:52];
        f0    = s4_bits_reg[51:0];
        dbits = {1'b0, s4_eb_reg, 52'd0} + sig;
        out_bits_next = '0;
        out_se_next   = '0;
        unique case (s4_type_reg)
            REQ_TO_EXT:
            begin
                if (e0 == 11'd0 && f0 == 52'd0)
                begin
                    out_bits_next = '0;
                    out_se_next   = '0;
                end
                else if (e0 == DblExpMax)
                begin
                    if (f0 == 52'd0)
                    begin
                        out_bits_next = '0;
                        out_se_next   = {s4_bits_reg[63], ExtExpMax};
                    end
                    else
                    begin
                        out_bits_next = TopBit;
                        out_se_next   = {1'b0, ExtExpMax};
                    end
                end
                else if (e0 == 11'd0)
                begin
                    out_bits_next = s4_mn_reg;
                    out_se_next   = {s4_bits_reg[63], s4_exp0_reg};
                end
                else
                begin
                    out_bits_next = TopBit | {f0, 11'd0};
                    out_se_next   = {s4_bits_reg[63], 4'd0, e0} + {1'b0, ExtNrmOfs};
                end
            end
            REQ_TO_DBL:
            begin
                out_se_next = '0;
                if (s4_inf_reg)
                begin
                    out_bits_next = {s4_sign_reg, DblExpMax, 52'd0};
                end
                else if (s4_zero_reg)
                begin
                    out_bits_next = {s4_sign_reg, 63'd0};
                end
                else if (s4_nrm_reg)
                begin
                    if (dbits[62:52] == DblExpMax)
                    begin
                        out_bits_next = {s4_sign_reg, DblExpMax, 52'd0};
                    end
                    else
                    begin
                        out_bits_next = {s4_sign_reg, dbits[62:0]};
                    end
                end
                else
                begin
                    out_bits_next = {s4_sign_reg, sig[62:0]};
                end
            end
            default:
            begin
                out_bits_next = '0;
            end
        endcase
    end

    // payload stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_type_reg  <= s_axis_tuser;
            s1_bits_reg  <= s_axis_tdata[63:0];
            s1_se_reg    <= s_axis_tdata[79:64];

            s2_type_reg  <= s1_type_reg;
            s2_bits_reg  <= s1_bits_reg;
            s2_se_reg    <= s1_se_reg;
            s2_val_reg   <= s2_val_next;
            s2_grp_reg   <= s2_grp_next;

            s3_type_reg  <= s2_type_reg;
            s3_bits_reg  <= s2_bits_reg;
            s3_se_reg    <= s2_se_reg;
            s3_val_reg   <= s2_val_reg;
            s3_lz_reg    <= s3_lz_next;
            s3_zero_reg  <= s3_zero_next;

            s4_type_reg  <= s3_type_reg;
            s4_bits_reg  <= s3_bits_reg;
            s4_sign_reg  <= s3_se_reg[15];
            s4_mn_reg    <= s4_mn_next;
            s4_exp0_reg  <= s4_exp0_next;
            s4_inf_reg   <= s4_inf_next;
            s4_zero_reg  <= s3_zero_reg;
            s4_nrm_reg   <= s4_nrm_next;
            s4_flush_reg <= s4_flush_next;
            s4_sh_reg    <= s4_sh_next;
            s4_eb_reg    <= s4_eb_next;

            out_bits_reg <= out_bits_next;
            out_se_reg   <= out_se_next;
        end
    end
endmodule

/* hw/rtl/dxf_lzc_group.sv */
module dxf_lzc_group
(
    input  logic [63:0]      val,
    output dxf_pkg::grp_lz_t grp
);
    import dxf_pkg::*;

    // leading zeros within each byte, bytes independent
    always_comb
    begin
        grp = '0;
        for (int g = 0; g < 8; g++)
        begin
            grp.nz[g]  = |val[g*8 +: 8];
            grp.lz8[g] = 3'd7;
            for (int b = 0; b < 8; b++)
            begin
                if (val[g*8 + b])
                begin
                    grp.lz8[g] = 3'(7 - b);
                end
            end
        end
    end
endmodule

/* hw/rtl/dxf_round.sv */
module dxf_round
(
    input  logic [63:0] mn,
    input  logic [6:0]  shamt,
    input  logic        flush,
    output logic [63:0] sig
);
    import dxf_pkg::*;

    logic [127:0] ext;
    logic         rnd;
    logic         sticky;

    // shift right with guard/sticky, round to nearest even
    always_comb
    begin
        ext    = {mn, 64'd0} >> shamt;
        rnd    = ext[63];
        sticky = |ext[62:0];
        if (flush)
        begin
            sig = '0;
        end
        else
        begin
            sig = ext[127:64] + {63'd0, rnd & (sticky | ext[64])};
        end
    end
endmodule

/* hw/rtl/dxf_checker.sv */
`include "double_extended_float_converter_core_macros.svh"

module dxf_port_props
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    logic        out_sign;
    logic [14:0] out_exp;
    logic [63:0] out_bits;
    logic        out_top;

    assign out_sign = m_axis_tdata[79];
    assign out_exp  = m_axis_tdata[78:64];
    assign out_bits = m_axis_tdata[63:0];
    assign out_top  = (out_exp == 15'h7FFF);

    // stalled output word holds
    `DXF_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // input side is open exactly when output can move
    `DXF_ASSERT_IMP(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    // max extended exponent only for infinity or the canonical NaN
    `DXF_ASSERT_IMP(a_special, m_axis_tvalid && out_top, (out_bits == 64'd0) || (out_bits == 64'h8000_0000_0000_0000))
    // NaN result always carries a clear sign
    `DXF_ASSERT_IMP(a_nan_sign, m_axis_tvalid && out_top && out_bits[63], !out_sign)
endmodule

bind double_extended_float_converter_core dxf_port_props u_dxf_port_props
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
